// ----- rtl/kwc_pkg.sv -----
// package: constants and types for the k-mer co-occurrence counter
`default_nettype none
package kwc_pkg;
  localparam int unsigned MaxK      = 4;
  localparam int unsigned MaxWindow = 2048;
  localparam int unsigned CodeW     = 2 * MaxK;
  localparam int unsigned CellW     = 2 * CodeW;
  localparam int unsigned Cells     = 1 << CellW;
  localparam int unsigned WinAw     = $clog2(MaxWindow);
  localparam int unsigned WinFw     = $clog2(MaxWindow + 1);
  localparam int unsigned PosW      = 16;
  localparam int unsigned CntW      = 32;
  localparam int unsigned SumW      = 48;
  localparam int unsigned MeanW     = 20;
  localparam int unsigned KW        = 3;
  localparam int unsigned WsW       = 12;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 12;
  localparam logic [MeanW-1:0] MeanMax = MeanW'(524288);

  localparam logic [1:0] KindBase = 2'd0;
  localparam logic [1:0] KindEnd  = 2'd1;
  localparam logic [1:0] KindRead = 2'd2;

  localparam logic [CfgIdxW-1:0] RegKmerLength = 1'd0;
  localparam logic [CfgIdxW-1:0] RegWindowSize = 1'd1;

  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChT = 8'h54;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
    logic [7:0] row_index;
    logic [7:0] col_index;
  } in_item_t;

  typedef struct packed {
    logic [CntW-1:0]  pair_frequency;
    logic [SumW-1:0]  pair_distance_total;
    logic [MeanW-1:0] mean_distance;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

  // reverse complement of the low k bases
  function automatic logic [CodeW-1:0] rev_comp(logic [CodeW-1:0] code, logic [KW-1:0] k);
    logic [CodeW-1:0] r;
    logic [CodeW-1:0] c;
    r = '0;
    c = code;
    for (int i = 0; i < MaxK; i++) begin
      if (KW'(i) < k) begin
        r = {r[CodeW-3:0], c[1:0] ^ 2'b10};
        c = c >> 2;
      end
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/kwc_if.sv -----
// valid/ready channel interfaces
`default_nettype none
interface kwc_in_if;
  import kwc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kwc_out_if;
  import kwc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kwc_cfg_if;
  import kwc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/kmer_window_cooccurrence_top.sv -----
// k-mer co-occurrence counter over a sliding window of k-mers
//
//  channel   dir  carries
//  in_ch     in   kind, symbol, row_index, col_index
//  out_ch    out  pair_frequency, pair_distance_total, mean_distance
//  cfg_ch    in   register index, write data
//
// after reset a clearing pass sweeps all 65536 cells of the pair memory, no input taken
// a complete k-mer goes through one shared read-modify-write path to the pair memory,
// reading (StPrd) and writing (StPwr) each window entry, in two passes; with an empty
// window it goes straight to StStore; other base, end and unknown transactions stay in StIdle
// a read-out runs StRdA, StRdB, the bit-serial divider (56 steps), then waits in StOut to be taken
`default_nettype none
module kmer_window_cooccurrence_top
  import kwc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kwc_in_if.sink    in_ch,
  kwc_out_if.source out_ch,
  kwc_cfg_if.sink   cfg_ch
);
  typedef enum logic [9:0] {
    StClear = 10'b0000000001,
    StIdle  = 10'b0000000010,
    StWrd   = 10'b0000000100,
    StPrd   = 10'b0000001000,
    StPwr   = 10'b0000010000,
    StStore = 10'b0000100000,
    StRdA   = 10'b0001000000,
    StRdB   = 10'b0010000000,
    StDiv   = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [KW-1:0]  k_reg_q;
  logic [WsW-1:0] w_reg_q;

  // pair memories
  logic [CntW-1:0] cnt_mem [Cells];
  logic [SumW-1:0] sum_mem [Cells];
  logic [CellW-1:0] p_raddr, p_waddr;
  logic             p_we;
  logic [CntW-1:0]  p_wcnt, cnt_rd_q;
  logic [SumW-1:0]  p_wsum, sum_rd_q;

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      cnt_mem[p_waddr] <= p_wcnt;
      sum_mem[p_waddr] <= p_wsum;
    end
    cnt_rd_q <= cnt_mem[p_raddr];
    sum_rd_q <= sum_mem[p_raddr];
  end

  // window memory: code and position
  logic [CodeW+PosW-1:0] win_mem [MaxWindow];
  logic [WinAw-1:0]      w_raddr, w_waddr;
  logic                  w_we;
  logic [CodeW+PosW-1:0] w_wdata, w_rd_q;

  always_ff @(posedge clk_i) begin
    if (w_we) win_mem[w_waddr] <= w_wdata;
    w_rd_q <= win_mem[w_raddr];
  end

  logic [CodeW-1:0]  kmer_q, kmer_d;
  logic [KW-1:0]     filled_q, filled_d;
  logic [PosW-1:0]   pos_q, pos_d, cpos_q, cpos_d;
  logic [WinAw-1:0]  head_q, head_d;
  logic [WinFw-1:0]  fill_q, fill_d, idx_q, idx_d;
  logic              pass_q, pass_d;
  logic [CellW-1:0]  clr_q, clr_d, cell_q, cell_d;
  logic [CodeW-1:0]  cur_q, cur_d, rcur_q, rcur_d;
  logic [CellW-1:0]  upd_q, upd_d;
  logic [PosW-1:0]   dist_q, dist_d;
  // divider
  logic [SumW+8-1:0] rem_q, rem_d;  // dividend shifts out through here
  logic [CntW:0]     part_q, part_d;
  logic [SumW+8-1:0] quo_q, quo_d;
  logic [5:0]        step_q, step_d;
  logic [CntW-1:0]   dcnt_q, dcnt_d;
  logic [SumW-1:0]   dsum_q, dsum_d;
  out_item_t         out_q, out_d;

  logic [KW-1:0]    k_eff;
  logic [WinFw-1:0] w_eff;
  logic [CodeW-1:0] kmask;
  always_comb begin
    k_eff = (k_reg_q == '0) ? KW'(1) : (k_reg_q > KW'(MaxK)) ? KW'(MaxK) : k_reg_q;
    w_eff = (w_reg_q == '0) ? WinFw'(1) :
            (WinFw'(w_reg_q) > WinFw'(MaxWindow)) ? WinFw'(MaxWindow) : WinFw'(w_reg_q);
    kmask = CodeW'((1 << (2 * k_eff)) - 1);
  end

  assign in_ch.ready  = (state_q == StIdle);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_q == StOut);
  assign out_ch.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_reg_q <= KW'(4);
      w_reg_q <= WsW'(2048);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        RegKmerLength: k_reg_q <= cfg_ch.data.data[KW-1:0];
        RegWindowSize: w_reg_q <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  logic             is_acgt;
  logic [CodeW-1:0] nk;
  logic [KW-1:0]    nf;
  logic [WinAw-1:0] tail;
  logic [CntW:0]    trial;
  logic [CellW-1:0] rd_cell;
  logic [SumW:0]    sum_add;

  always_comb begin
    state_d = state_q;
    kmer_d = kmer_q; filled_d = filled_q; pos_d = pos_q; cpos_d = cpos_q;
    head_d = head_q; fill_d = fill_q; idx_d = idx_q; pass_d = pass_q;
    clr_d = clr_q; cell_d = cell_q; cur_d = cur_q; rcur_d = rcur_q;
    upd_d = upd_q; dist_d = dist_q; rem_d = rem_q; part_d = part_q;
    quo_d = quo_q; step_d = step_q; dcnt_d = dcnt_q; dsum_d = dsum_q; out_d = out_q;
    p_raddr = upd_q; p_waddr = upd_q; p_we = 1'b0; p_wcnt = '0; p_wsum = '0;
    w_raddr = head_q + idx_q[WinAw-1:0]; w_waddr = '0; w_we = 1'b0; w_wdata = '0;
    is_acgt = (in_ch.data.symbol == ChA) || (in_ch.data.symbol == ChC) ||
              (in_ch.data.symbol == ChG) || (in_ch.data.symbol == ChT);
    nk = (((kmer_q << 2) & kmask) + CodeW'(in_ch.data.symbol[2:1])) & kmask;
    nf = filled_q + KW'(1);
    tail = '0;
    trial = '0;
    rd_cell = {in_ch.data.row_index[CodeW-1:0], in_ch.data.col_index[CodeW-1:0]};
    sum_add = {1'b0, sum_rd_q} + (SumW+1)'(dist_q);
    unique case (state_q)
      StClear: begin
        p_we = 1'b1; p_waddr = clr_q;
        clr_d = clr_q + CellW'(1);
        if (clr_q == '1) state_d = StIdle;
      end
      StIdle: begin
        if (in_ch.valid) begin
          unique case (in_ch.data.kind)
            KindBase: begin
              pos_d = pos_q + PosW'(1);
              cpos_d = pos_q;
              if (!is_acgt) begin
                kmer_d = '0; filled_d = '0; head_d = '0; fill_d = '0;
              end else begin
                kmer_d = nk; filled_d = nf;
                if (nf >= k_eff) begin
                  cur_d = nk; rcur_d = rev_comp(nk, k_eff);
                  idx_d = '0; pass_d = 1'b0;
                  state_d = (fill_q == '0) ? StStore : StWrd;
                end
              end
            end
            KindEnd: begin
              kmer_d = '0; filled_d = '0; head_d = '0; fill_d = '0; pos_d = '0;
            end
            KindRead: begin
              cell_d = rd_cell; p_raddr = rd_cell;
              state_d = StRdA;
            end
            default: ;
          endcase
        end
      end
      StWrd: state_d = StPrd;  // window entry read in flight
      StPrd: begin
        // window entry in hand: form pair address and distance
        dist_d = cpos_q - w_rd_q[PosW-1:0];
        if (!pass_q) upd_d = {w_rd_q[CodeW+PosW-1:PosW], cur_q};
        else upd_d = {rev_comp(w_rd_q[CodeW+PosW-1:PosW] & kmask, k_eff), rcur_q};
        p_raddr = upd_d;
        state_d = StPwr;
      end
      StPwr: begin
        p_we = 1'b1;
        p_wcnt = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + CntW'(1);
        p_wsum = sum_add[SumW] ? '1 : sum_add[SumW-1:0];
        idx_d = idx_q + WinFw'(1);
        w_raddr = head_q + idx_d[WinAw-1:0];
        state_d = StPrd;
        if (idx_d == fill_q) begin
          idx_d = '0;
          w_raddr = head_q;
          if (pass_q) state_d = StStore;
          else begin
            pass_d = 1'b1;
            state_d = StWrd;
          end
        end
      end
      StStore: begin
        // drop oldest entries until below window size, then append
        if (fill_q >= w_eff) begin
          head_d = head_q + WinAw'(fill_q - w_eff + WinFw'(1));
          fill_d = w_eff - WinFw'(1);
        end
        tail = head_d + fill_d[WinAw-1:0];
        w_we = 1'b1; w_waddr = tail; w_wdata = {cur_q, cpos_q};
        fill_d = fill_d + WinFw'(1);
        filled_d = k_eff - KW'(1);
        state_d = StIdle;
      end
      StRdA: begin
        p_raddr = cell_q;
        state_d = StRdB;
      end
      StRdB: begin
        dcnt_d = cnt_rd_q; dsum_d = sum_rd_q;
        rem_d = {sum_rd_q, 8'd0}; part_d = '0; quo_d = '0;
        step_d = '0;
        state_d = StDiv;
      end
      StDiv: begin
        // restoring division, one quotient bit per cycle
        trial = {part_q[CntW-1:0], rem_q[SumW+8-1]};
        rem_d = rem_q << 1;
        if (trial >= {1'b0, dcnt_q}) begin
          part_d = trial - {1'b0, dcnt_q};
          quo_d = {quo_q[SumW+8-2:0], 1'b1};
        end else begin
          part_d = trial;
          quo_d = {quo_q[SumW+8-2:0], 1'b0};
        end
        step_d = step_q + 6'd1;
        if (step_q == 6'(SumW + 8 - 1)) begin
          out_d.pair_frequency = dcnt_q;
          out_d.pair_distance_total = dsum_q;
          if (dcnt_q == '0) out_d.mean_distance = '0;
          else if (quo_d > (SumW+8)'(MeanMax)) out_d.mean_distance = MeanMax;
          else out_d.mean_distance = quo_d[MeanW-1:0];
          state_d = StOut;
        end
      end
      StOut: if (out_ch.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      kmer_q <= '0; filled_q <= '0; pos_q <= '0; head_q <= '0; fill_q <= '0;
      idx_q <= '0; pass_q <= 1'b0; clr_q <= '0; step_q <= '0;
    end else begin
      state_q <= state_d;
      kmer_q <= kmer_d; filled_q <= filled_d; pos_q <= pos_d; head_q <= head_d;
      fill_q <= fill_d; idx_q <= idx_d; pass_q <= pass_d; clr_q <= clr_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cpos_q <= cpos_d; cell_q <= cell_d; cur_q <= cur_d; rcur_q <= rcur_d;
    upd_q <= upd_d; dist_q <= dist_d; rem_q <= rem_d; part_q <= part_d;
    quo_q <= quo_d; dcnt_q <= dcnt_d; dsum_q <= dsum_d; out_q <= out_d;
  end
endmodule
`default_nettype wire

// ----- rtl/kwc_checker.sv -----
// port-level checker for the k-mer co-occurrence counter
`default_nettype none
module kwc_checker
  import kwc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_i
);
  // never ready for input while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input ready with result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.pair_frequency == '0 |-> out_data_i.mean_distance == '0)
    else $error("mean nonzero for empty cell");

  a_mean_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.mean_distance <= MeanMax)
    else $error("mean above clamp");

  // a taken result frees the block for the next input
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> in_ready_i) else $error("no ready after result");
endmodule

bind kmer_window_cooccurrence_top kwc_checker u_kwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_data_i  (out_ch.data)
);
`default_nettype wire
